// ===== rtl/frame_difference_motion_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Frame difference motion detector assertion macros
// Shared assertion forms for the checker of the motion detector.
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_DEFINES_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_DEFINES_SVH

// Checked only while the block is out of reset.
`define FDMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FDMD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fdmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion detector package
// Geometry limits, widths, filter taps and shared types of the detector.
// ----------------------------------------------------------------------------
package fdmd_pkg;

	localparam int MAX_WIDTH  = 640;
	localparam int MAX_HEIGHT = 480;
	localparam int MIN_DIM    = 5;

	localparam int PIX_W       = 8;
	localparam int W_W         = $clog2(MAX_WIDTH + 1);
	localparam int Y_W         = $clog2(MAX_HEIGHT + 3);
	localparam int XA_W        = $clog2(MAX_WIDTH);
	localparam int PIX_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W       = $clog2(PIX_DEPTH);
	localparam int AREA_W      = $clog2(PIX_DEPTH + 1);
	localparam int LINES       = 4;
	localparam int LINE_WORD_W = LINES * PIX_W;
	localparam int VSUM_W      = 16;
	localparam int HSUM_W      = 24;
	localparam int GRAY_SUM_W  = 22;

	localparam int FW_W       = 10;
	localparam int FH_W       = 9;
	localparam int THR_W      = 8;
	localparam int PCT_W      = 7;
	localparam int MINF_W     = 8;
	localparam int CNT_W      = 19;
	localparam int RUN_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int HUND_W     = 7;
	localparam int PROD_W     = (CNT_W + HUND_W > PCT_W + AREA_W) ?
		(CNT_W + HUND_W) : (PCT_W + AREA_W);

	localparam logic [PIX_W-1:0] TAP_OUT = 8'd41;
	localparam logic [PIX_W-1:0] TAP_IN  = 8'd56;
	localparam logic [PIX_W-1:0] TAP_MID = 8'd62;

	localparam logic [GRAY_SUM_W-1:0] GRAY_KR    = 22'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KG    = 22'd9617;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KB    = 22'd1868;
	localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

	localparam logic [HSUM_W-1:0] BLUR_ROUND = 24'd32768;
	localparam logic [HUND_W-1:0] HUNDRED    = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH     = 3'd0,
		CFG_FRAME_HEIGHT    = 3'd1,
		CFG_DIFF_THRESHOLD  = 3'd2,
		CFG_CHANGED_PERCENT = 3'd3,
		CFG_MOTION_FRAMES   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_RECV,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

	typedef enum logic [2:0] {
		HS_X0,
		HS_X1,
		HS_X2,
		HS_X3,
		HS_MID
	} hsel_t;

	// Row controls for the vertical pass.
	typedef struct packed {
		logic issue;
		logic wr;
		logic top0;
		logic top1;
		logic bot0;
		logic bot1;
	} vctl_t;

	// Column controls for the horizontal pass.
	typedef struct packed {
		logic  shift;
		logic  outv;
		logic  last;
		hsel_t sel;
	} hctl_t;

	function automatic logic [W_W-1:0] clamp_w(input logic [FW_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		if (t < 32'(MIN_DIM)) t = 32'(MIN_DIM);
		else if (t > 32'(MAX_WIDTH)) t = 32'(MAX_WIDTH);
		return W_W'(t);
	endfunction

	function automatic logic [Y_W-1:0] clamp_h(input logic [FH_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		if (t < 32'(MIN_DIM)) t = 32'(MIN_DIM);
		else if (t > 32'(MAX_HEIGHT)) t = 32'(MAX_HEIGHT);
		return Y_W'(t);
	endfunction

endpackage

// ===== rtl/fdmd_vsum.sv =====
// ----------------------------------------------------------------------------
// Motion detector vertical pass
// Four-line gray store with read-modify-write and the vertical 5-tap sum.
// ----------------------------------------------------------------------------
module fdmd_vsum import fdmd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  vctl_t              ctl,
	input  logic [XA_W-1:0]    x,
	input  logic [PIX_W-1:0]   gray,
	output logic [VSUM_W-1:0]  vsum_s2
);

	// Each word holds one column of the four previous lines, newest on top.
	logic [LINE_WORD_W-1:0] line_mem [MAX_WIDTH];

	logic [LINE_WORD_W-1:0] rd_s1;
	vctl_t                  ctl_s1;
	logic [XA_W-1:0]        x_s1;
	logic [PIX_W-1:0]       gray_s1;

	logic [PIX_W-1:0] a0, a1, a2, a3, a4;
	logic [PIX_W-1:0] t0, t1, t3, t4;
	logic [VSUM_W-1:0] vsum;

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			rd_s1 <= line_mem[x];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.issue && ctl_s1.wr) begin
			line_mem[x_s1] <= {gray_s1, a3, a2, a1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		gray_s1 <= gray;
		vsum_s2 <= vsum;
	end

	always_comb begin
		a0 = rd_s1[PIX_W-1:0];
		a1 = rd_s1[2*PIX_W-1:PIX_W];
		a2 = rd_s1[3*PIX_W-1:2*PIX_W];
		a3 = rd_s1[4*PIX_W-1:3*PIX_W];
		a4 = gray_s1;
		// Reflect-101 at the top and bottom edges of the frame.
		t1 = ctl_s1.top0 ? a3 : a1;
		t0 = ctl_s1.top0 ? a4 : (ctl_s1.top1 ? a2 : a0);
		t3 = ctl_s1.bot1 ? a1 : a3;
		t4 = ctl_s1.bot1 ? a0 : (ctl_s1.bot0 ? a2 : a4);
		vsum = VSUM_W'(a2) * VSUM_W'(TAP_MID)
			+ (VSUM_W'(t1) + VSUM_W'(t3)) * VSUM_W'(TAP_IN)
			+ (VSUM_W'(t0) + VSUM_W'(t4)) * VSUM_W'(TAP_OUT);
	end

endmodule

// ===== rtl/frame_difference_motion_detector.sv =====
// ----------------------------------------------------------------------------
// Frame difference motion detector
// Gray conversion, 5x5 blur, frame differencing and motion run tracking.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel in raster order, one word per cycle while
// in_ready is high, with end_of_frame set on the last pixel. Every frame
// gives one out word: motion flag, event flag, changed pixel count and run.
// Configuration words on the cfg channel are taken at any cycle; cfg_ready
// is always high, and geometry must hold steady within a frame.
// The blur trails the input by two lines. After the end-of-frame pixel the
// block stops taking pixels while it pads any missing pixels with zero,
// runs the two bottom border lines and two border columns, and waits for
// the difference pipeline to drain. Otherwise one pixel is taken every
// cycle, limited by the single read and write port of the line store and
// the previous-frame memory. The result word is registered at the output
// once the last padding step has passed through stages s1 to s6.
// The last padding cycle waits while an earlier result is still held, so a
// stalled receiver stalls the next frame's end only.
// Reset clears the counters and state; the first frame never shows motion.
// ----------------------------------------------------------------------------
module frame_difference_motion_detector import fdmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PIX_W-1:0]       pixel_red,
	input  logic [PIX_W-1:0]       pixel_green,
	input  logic [PIX_W-1:0]       pixel_blue,
	input  logic                   end_of_frame,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   frame_has_motion,
	output logic                   motion_event,
	output logic [CNT_W-1:0]       changed_pixels,
	output logic [RUN_W-1:0]       motion_run
);

	logic [FW_W-1:0]   frame_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [THR_W-1:0]  threshold_q;
	logic [PCT_W-1:0]  percent_q;
	logic [MINF_W-1:0] min_frames_q;

	state_t state_q, state_d;

	logic [W_W-1:0] px_q;
	logic [Y_W-1:0] py_q;
	logic [W_W-1:0] w_eff;
	logic [Y_W-1:0] h_eff;

	logic prev_valid_q;
	logic [W_W-1:0] stored_w_q;
	logic [Y_W-1:0] stored_h_q;
	logic cmp;

	logic accept, issue, row_in, is_last, out_free, frame_end;
	logic [GRAY_SUM_W-1:0] gray_sum;
	logic [PIX_W-1:0] gray_src;
	vctl_t vctl;
	hctl_t hctl, hctl_s1, hctl_s2;
	logic [VSUM_W-1:0] vsum_s2;

	logic [VSUM_W-1:0] win1_q, win2_q, win3_q, win4_q;
	logic [VSUM_W-1:0] hc, hpl, hpr, hql, hqr;
	logic [HSUM_W-1:0] hsum, hsum_s3;
	logic [IDX_W-1:0] oidx_q, oidx_s3;
	logic outv_s3, last_s3;

	logic [PIX_W-1:0] prev_mem [PIX_DEPTH];
	logic [PIX_W-1:0] prev_rd_s3;
	logic [HSUM_W-1:0] rsum;
	logic [PIX_W-1:0] cur;
	logic changed;
	logic chg_s4, last_s4;

	logic [CNT_W-1:0] count_q, count_next;
	logic [AREA_W-1:0] area_q;
	logic fin_s5, fin_s6;
	logic [CNT_W-1:0] cnt_s5, cnt_s6;
	logic [PROD_W-1:0] lhs_s6, rhs_s6;
	logic motion;
	logic [RUN_W-1:0] run_q, run_next;

	logic out_valid_q, out_motion_q, out_event_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [RUN_W-1:0] out_run_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(640);
			frame_height_q <= FH_W'(480);
			threshold_q    <= THR_W'(10);
			percent_q      <= PCT_W'(5);
			min_frames_q   <= MINF_W'(3);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:     frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT:    frame_height_q <= cfg_data[FH_W-1:0];
				CFG_DIFF_THRESHOLD:  threshold_q    <= cfg_data[THR_W-1:0];
				CFG_CHANGED_PERCENT: percent_q      <= cfg_data[PCT_W-1:0];
				CFG_MOTION_FRAMES:   min_frames_q   <= cfg_data[MINF_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = clamp_w(frame_width_q);
	assign h_eff = clamp_h(frame_height_q);

	// Input side and sequencer.
	assign gray_sum = GRAY_SUM_W'(pixel_red) * GRAY_KR
		+ GRAY_SUM_W'(pixel_green) * GRAY_KG
		+ GRAY_SUM_W'(pixel_blue) * GRAY_KB + GRAY_ROUND;

	assign row_in   = py_q < h_eff;
	assign is_last  = (py_q == h_eff + Y_W'(2)) && (px_q == W_W'(1));
	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign frame_end = accept && end_of_frame;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RECV:  if (frame_end) state_d = ST_FLUSH;
			ST_FLUSH: if (issue && is_last) state_d = ST_DRAIN;
			ST_DRAIN: if (fin_s6) state_d = ST_RECV;
			default:  state_d = ST_RECV;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		gray_src = '0;
		case (state_q)
			ST_RECV: begin
				in_ready = 1'b1;
				issue    = in_valid && row_in;
				gray_src = gray_sum[GRAY_SUM_W-1 -: PIX_W];
			end
			ST_FLUSH: begin
				issue = !is_last || out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
			px_q    <= '0;
			py_q    <= '0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				if (is_last) begin
					px_q <= '0;
					py_q <= '0;
				end else if (px_q + W_W'(1) == w_eff) begin
					px_q <= '0;
					py_q <= py_q + Y_W'(1);
				end else begin
					px_q <= px_q + W_W'(1);
				end
			end
		end
	end

	// A frame is compared only against a stored frame of the same geometry.
	// The stored geometry moves on once the frame's verdict is out.
	assign cmp = prev_valid_q && stored_w_q == w_eff && stored_h_q == h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			stored_w_q   <= '0;
			stored_h_q   <= '0;
		end else if (fin_s6) begin
			prev_valid_q <= 1'b1;
			stored_w_q   <= w_eff;
			stored_h_q   <= h_eff;
		end
	end

	always_comb begin
		vctl.issue = issue;
		vctl.wr    = py_q <= h_eff;
		vctl.top0  = py_q == Y_W'(2);
		vctl.top1  = py_q == Y_W'(3);
		vctl.bot0  = py_q == h_eff;
		vctl.bot1  = py_q == h_eff + Y_W'(1);

		hctl.shift = issue && py_q >= Y_W'(2) && py_q <= h_eff + Y_W'(2);
		hctl.outv  = issue && ((px_q >= W_W'(2) && hctl.shift) ||
			(px_q < W_W'(2) && py_q >= Y_W'(3) && py_q <= h_eff + Y_W'(2)));
		hctl.last  = issue && is_last;
		if (px_q == W_W'(0))      hctl.sel = HS_X0;
		else if (px_q == W_W'(1)) hctl.sel = HS_X1;
		else if (px_q == W_W'(2)) hctl.sel = HS_X2;
		else if (px_q == W_W'(3)) hctl.sel = HS_X3;
		else                      hctl.sel = HS_MID;
	end

	fdmd_vsum u_vsum (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (vctl),
		.x       (px_q[XA_W-1:0]),
		.gray    (gray_src),
		.vsum_s2 (vsum_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hctl_s1 <= '0;
			hctl_s2 <= '0;
		end else begin
			hctl_s1 <= hctl;
			hctl_s2 <= hctl_s1;
		end
	end

	// Horizontal pass. The first two columns of a line finish the last two
	// outputs of the line before it, whose window is still held.
	always_comb begin
		hc  = win2_q;
		hpl = win3_q;
		hpr = win1_q;
		hql = win4_q;
		hqr = vsum_s2;
		case (hctl_s2.sel)
			HS_X0: hqr = win2_q;
			HS_X1: begin
				hpr = win3_q;
				hqr = win4_q;
			end
			HS_X2: begin
				hpl = win1_q;
				hql = vsum_s2;
			end
			HS_X3: hql = win2_q;
			default: ;
		endcase
		hsum = HSUM_W'(hc) * HSUM_W'(TAP_MID)
			+ (HSUM_W'(hpl) + HSUM_W'(hpr)) * HSUM_W'(TAP_IN)
			+ (HSUM_W'(hql) + HSUM_W'(hqr)) * HSUM_W'(TAP_OUT);
	end

	always_ff @(posedge clk) begin
		if (hctl_s2.shift) begin
			win1_q <= vsum_s2;
			win2_q <= win1_q;
			win3_q <= win2_q;
			win4_q <= win3_q;
		end
		hsum_s3 <= hsum;
		oidx_s3 <= oidx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oidx_q  <= '0;
			outv_s3 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			outv_s3 <= hctl_s2.outv;
			last_s3 <= hctl_s2.last;
			if (hctl_s2.last) begin
				oidx_q <= '0;
			end else if (hctl_s2.outv) begin
				oidx_q <= oidx_q + IDX_W'(1);
			end
		end
	end

	// Previous blurred frame: read one pixel ahead, write back the new one.
	always_ff @(posedge clk) begin
		if (hctl_s2.outv) begin
			prev_rd_s3 <= prev_mem[oidx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (outv_s3) begin
			prev_mem[oidx_s3] <= cur;
		end
	end

	always_comb begin
		rsum    = hsum_s3 + BLUR_ROUND;
		cur     = rsum[HSUM_W-1 -: PIX_W];
		changed = prev_rd_s3 > cur && (prev_rd_s3 - cur) > threshold_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_s4  <= 1'b0;
			last_s4 <= 1'b0;
		end else begin
			chg_s4  <= outv_s3 && changed && cmp;
			last_s4 <= last_s3;
		end
	end

	// Count, then decide on motion with the frame area.
	assign count_next = (chg_s4 && count_q != '1) ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fin_s5  <= 1'b0;
			fin_s6  <= 1'b0;
		end else begin
			count_q <= last_s4 ? '0 : count_next;
			fin_s5  <= last_s4;
			fin_s6  <= fin_s5;
		end
	end

	always_ff @(posedge clk) begin
		area_q <= AREA_W'(w_eff * h_eff);
		cnt_s5 <= count_next;
		cnt_s6 <= cnt_s5;
		lhs_s6 <= PROD_W'(cnt_s5) * PROD_W'(HUNDRED);
		rhs_s6 <= PROD_W'(percent_q) * PROD_W'(area_q);
	end

	always_comb begin
		motion = cmp && lhs_s6 > rhs_s6;
		if (!motion)            run_next = '0;
		else if (run_q == '1)   run_next = run_q;
		else                    run_next = run_q + RUN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_s6) begin
				run_q       <= run_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_s6) begin
			out_motion_q <= motion;
			out_event_q  <= run_next >= min_frames_q;
			out_cnt_q    <= cnt_s6;
			out_run_q    <= run_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_has_motion = out_motion_q;
	assign motion_event     = out_event_q;
	assign changed_pixels   = out_cnt_q;
	assign motion_run       = out_run_q;

endmodule

// ===== rtl/fdmd_checker.sv =====
// ----------------------------------------------------------------------------
// Motion detector port checker
// Watches the result channel of the detector over time.
// ----------------------------------------------------------------------------
`include "frame_difference_motion_detector_defines.svh"

module fdmd_checker import fdmd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   frame_has_motion,
	input logic [CNT_W-1:0]       changed_pixels,
	input logic [RUN_W-1:0]       motion_run
);

	// A stalled result word keeps its count.
	`FDMD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(changed_pixels), "result word dropped or changed while stalled")

	// A motion frame always leaves a non-empty run.
	`FDMD_ASSERT(a_motion_run, out_valid && frame_has_motion |-> motion_run != '0, "motion frame with empty run")

	// A still frame always ends the run.
	`FDMD_ASSERT(a_still_run, out_valid && !frame_has_motion |-> motion_run == '0, "still frame did not clear the run")

	`FDMD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result word shown during reset")

endmodule

bind frame_difference_motion_detector fdmd_checker u_fdmd_checker (.*);
